### rtl/mtmr_pkg.sv
package mtmr_pkg;

   // Width of the prescale divider and of its counter.
   localparam int DIVIDER_BITS = 10;

   // Request kinds on the input channel (code 3 is unused and does nothing).
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_WRITE = 2'd2;

   // Register map.
   localparam logic [2:0] REG_CONTROL = 3'd0;
   localparam logic [2:0] REG_DIVIDER = 3'd1;
   localparam logic [2:0] REG_TIME_LO = 3'd2;
   localparam logic [2:0] REG_TIME_HI = 3'd3;
   localparam logic [2:0] REG_CMP_LO  = 3'd4;
   localparam logic [2:0] REG_CMP_HI  = 3'd5;

   // Control register bit positions.
   localparam int CTRL_ENABLE_BIT = 0;
   localparam int CTRL_SOURCE_BIT = 1;

   // One request word as held in the input register.
   typedef struct packed {
      logic [1:0]  kind;
      logic        ext_pulse;
      logic [2:0]  reg_index;
      logic [31:0] write_data;
   } item_type;

   // Controls from the register file to the prescaler.
   typedef struct packed {
      logic                    tick;
      logic                    ext_pulse;
      logic                    enable;
      logic                    source_sel;
      logic [DIVIDER_BITS-1:0] divider;
   } presc_ctl_type;

endpackage

### rtl/mtmr_prescale.sv
module mtmr_prescale (
   input  logic                  clock,
   input  logic                  reset,
   input  mtmr_pkg::presc_ctl_type ctl,
   output logic                  advance
);

   logic [mtmr_pkg::DIVIDER_BITS-1:0] count_ff;
   logic [mtmr_pkg::DIVIDER_BITS-1:0] count_in;
   logic                              pulse;
   logic                              wrap;

   // External source counts only flagged ticks; core source counts every tick.
   assign pulse   = ctl.tick && ctl.enable && (ctl.source_sel ? ctl.ext_pulse : 1'b1);
   assign wrap    = (count_ff >= ctl.divider);
   assign advance = pulse && wrap;

   always_comb begin
      count_in = count_ff;
      if (pulse) begin
         if (wrap) begin
            count_in = '0;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

### rtl/mtmr_regs.sv
module mtmr_regs (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    go,
   input  mtmr_pkg::item_type      item,
   input  logic                    advance,
   output mtmr_pkg::presc_ctl_type ctl,
   output logic [31:0]             read_data,
   output logic                    irq_next
);

   logic                              enable_ff, enable_in;
   logic                              source_ff, source_in;
   logic [mtmr_pkg::DIVIDER_BITS-1:0] divider_ff, divider_in;
   logic [63:0]                       time_ff, time_in;
   logic [63:0]                       compare_ff, compare_in;
   logic                              wr;

   assign ctl.tick       = go && (item.kind == mtmr_pkg::REQ_TICK);
   assign ctl.ext_pulse  = item.ext_pulse;
   assign ctl.enable     = enable_ff;
   assign ctl.source_sel = source_ff;
   assign ctl.divider    = divider_ff;

   assign wr = go && (item.kind == mtmr_pkg::REQ_WRITE);

   always_comb begin
      enable_in  = enable_ff;
      source_in  = source_ff;
      divider_in = divider_ff;
      time_in    = advance ? time_ff + 64'd1 : time_ff;
      compare_in = compare_ff;
      if (wr) begin
         case (item.reg_index)
            mtmr_pkg::REG_CONTROL: begin
               enable_in = item.write_data[mtmr_pkg::CTRL_ENABLE_BIT];
               source_in = item.write_data[mtmr_pkg::CTRL_SOURCE_BIT];
            end
            mtmr_pkg::REG_DIVIDER: begin
               divider_in = item.write_data[mtmr_pkg::DIVIDER_BITS-1:0];
            end
            mtmr_pkg::REG_TIME_LO: time_in    = {time_ff[63:32], item.write_data};
            mtmr_pkg::REG_TIME_HI: time_in    = {item.write_data, time_ff[31:0]};
            mtmr_pkg::REG_CMP_LO:  compare_in = {compare_ff[63:32], item.write_data};
            mtmr_pkg::REG_CMP_HI:  compare_in = {item.write_data, compare_ff[31:0]};
            default: ;
         endcase
      end
   end

   always_comb begin
      read_data = '0;
      if (item.kind == mtmr_pkg::REQ_READ) begin
         case (item.reg_index)
            mtmr_pkg::REG_CONTROL: begin
               read_data[mtmr_pkg::CTRL_ENABLE_BIT] = enable_ff;
               read_data[mtmr_pkg::CTRL_SOURCE_BIT] = source_ff;
            end
            mtmr_pkg::REG_DIVIDER: read_data = 32'(divider_ff);
            mtmr_pkg::REG_TIME_LO: read_data = time_ff[31:0];
            mtmr_pkg::REG_TIME_HI: read_data = time_ff[63:32];
            mtmr_pkg::REG_CMP_LO:  read_data = compare_ff[31:0];
            mtmr_pkg::REG_CMP_HI:  read_data = compare_ff[63:32];
            default:               read_data = '0;
         endcase
      end
   end

   // Interrupt level as seen after this word's update.
   assign irq_next = (time_in >= compare_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         source_ff  <= 1'b0;
         divider_ff <= '0;
         time_ff    <= '0;
         compare_ff <= '1;
      end else begin
         enable_ff  <= enable_in;
         source_ff  <= source_in;
         divider_ff <= divider_in;
         time_ff    <= time_in;
         compare_ff <= compare_in;
      end
   end

endmodule

### rtl/machine_timer_with_prescaler.sv
// Machine timer with prescaler: a 64-bit time counter, a 64-bit compare
// register, a control register (bit 0 enable, bit 1 source: 0 core clock,
// 1 external reference) and a divider register. Each req word is a core
// clock tick (req_type 0, with req_ext_pulse flagging an external reference
// pulse), a register read (1) or a register write (2); registers are 32-bit
// halves at index 0 control, 1 divider, 2/3 time low/high, 4/5 compare
// low/high. While enabled, time advances once every divider+1 counted
// pulses. Every req word yields exactly one rsp word: rsp_read_data holds
// the addressed register for reads and zero otherwise, rsp_timer_irq is
// time >= compare after that word took effect. Throughput is one word per
// clock while rsp_ready stays high. The accepting edge loads the input
// register; once the result slot is free or drained, a later edge applies
// the register-file update and loads the result register. A stalled rsp
// holds the input register; req_ready follows rsp_ready in the same cycle.
// Reset leaves the timer disabled, divider and time zero, compare all ones.
module machine_timer_with_prescaler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic        req_ext_pulse,
   input  logic [2:0]  req_reg_index,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic        rsp_timer_irq
);

   // Input register
   logic               s1_valid_ff, s1_valid_in;
   mtmr_pkg::item_type s1_item_ff;
   logic               s1_go;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff;
   logic               rsp_irq_ff;

   mtmr_pkg::presc_ctl_type presc_ctl;
   logic                    advance;
   logic [31:0]             read_data;
   logic                    irq_next;

   // The word in the input register moves on when the result slot is free
   // or being drained this cycle.
   assign s1_go      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_go;
   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !s1_go);
   assign rsp_valid_in = s1_go || (rsp_valid_ff && !rsp_ready);

   mtmr_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .go        (s1_go),
      .item      (s1_item_ff),
      .advance   (advance),
      .ctl       (presc_ctl),
      .read_data (read_data),
      .irq_next  (irq_next)
   );

   mtmr_prescale u_prescale (
      .clock   (clock),
      .reset   (reset),
      .ctl     (presc_ctl),
      .advance (advance)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
         rsp_irq_ff   <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_go) begin
            rsp_data_ff <= read_data;
            rsp_irq_ff  <= irq_next;
         end
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff.kind       <= req_type;
         s1_item_ff.ext_pulse  <= req_ext_pulse;
         s1_item_ff.reg_index  <= req_reg_index;
         s1_item_ff.write_data <= req_write_data;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_timer_irq = rsp_irq_ff;

   // A word leaving the input register always lands in the result register.
   a_go_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_go |=> rsp_valid)
      else $error("word left input register but no rsp followed");

   // A stalled input word is never dropped.
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_go |=> s1_valid_ff)
      else $error("stalled input word lost");

   // Result register only loads when a word moves through.
   a_rsp_only_on_go: assert property (@(posedge clock) disable iff (reset)
      !s1_go |=> $stable(rsp_read_data) && $stable(rsp_timer_irq))
      else $error("rsp payload changed without a word");

   // Non-read words return zero data.
   a_nonread_zero: assert property (@(posedge clock) disable iff (reset)
      s1_go && (s1_item_ff.kind != mtmr_pkg::REQ_READ) |=> rsp_read_data == 32'd0)
      else $error("non-read word returned nonzero data");

endmodule

### tb/sv/tb_machine_timer_with_prescaler.sv
`timescale 1ns / 1ps

module tb_machine_timer_with_prescaler;

   // Cycles with no word moving on either side before the run is called hung.
   // The worst legal pause is a maximal send gap plus a maximal stall plus
   // the two-register pipeline, so this leaves a wide margin.
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_WORDS = 1400;
   // Unused request kind: the block must treat it as a no-op.
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam logic [2:0] REG_UNUSED = 3'd6;
   localparam logic [2:0] REG_SPARE  = 3'd7;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq;
   } timer_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = mtmr_pkg::REQ_TICK;
   logic        req_ext_pulse = 1'b0;
   logic [2:0]  req_reg_index = mtmr_pkg::REG_CONTROL;
   logic [31:0] req_write_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_read_data;
   logic        rsp_timer_irq;

   machine_timer_with_prescaler uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_ext_pulse  (req_ext_pulse),
      .req_reg_index  (req_reg_index),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .rsp_timer_irq  (rsp_timer_irq)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // ------------------------------------------------------------------
   // Shadow copy of the timer state, advanced once per accepted word.
   // ------------------------------------------------------------------
   logic                              sh_enable = 1'b0;
   logic                              sh_source = 1'b0;
   logic [mtmr_pkg::DIVIDER_BITS-1:0] sh_divider = '0;
   logic [mtmr_pkg::DIVIDER_BITS-1:0] sh_presc = '0;
   logic [63:0]                       sh_time_count = '0;
   logic [63:0]                       sh_compare = '1;

   timer_rsp_type      timer_rsp_q[$];     // responses still owed by the block
   mtmr_pkg::item_type pending_words_q[$]; // stimulus not yet presented
   int                 words_total = 0;
   int                 words_accepted = 0;
   int                 mismatch_count = 0;

   // Apply one word to the shadow state and queue the response it owes.
   task automatic step_timer_shadow(input mtmr_pkg::item_type w);
      logic [31:0] rd;
      logic        pulse;
      rd = '0;
      case (w.kind)
         mtmr_pkg::REQ_TICK: begin
            // external source: only flagged ticks count as prescaler pulses
            pulse = sh_source ? w.ext_pulse : 1'b1;
            if (sh_enable && pulse) begin
               // >= so a divider shrunk below the count fires on the next pulse
               if (sh_presc >= sh_divider) begin
                  sh_presc = '0;
                  sh_time_count = sh_time_count + 64'd1;
               end else begin
                  sh_presc = sh_presc + 1'b1;
               end
            end
         end
         mtmr_pkg::REQ_READ: begin
            case (w.reg_index)
               mtmr_pkg::REG_CONTROL: begin
                  rd[mtmr_pkg::CTRL_ENABLE_BIT] = sh_enable;
                  rd[mtmr_pkg::CTRL_SOURCE_BIT] = sh_source;
               end
               mtmr_pkg::REG_DIVIDER: rd = 32'(sh_divider);
               mtmr_pkg::REG_TIME_LO: rd = sh_time_count[31:0];
               mtmr_pkg::REG_TIME_HI: rd = sh_time_count[63:32];
               mtmr_pkg::REG_CMP_LO:  rd = sh_compare[31:0];
               mtmr_pkg::REG_CMP_HI:  rd = sh_compare[63:32];
               default:               rd = '0;
            endcase
         end
         mtmr_pkg::REQ_WRITE: begin
            case (w.reg_index)
               mtmr_pkg::REG_CONTROL: begin
                  sh_enable = w.write_data[mtmr_pkg::CTRL_ENABLE_BIT];
                  sh_source = w.write_data[mtmr_pkg::CTRL_SOURCE_BIT];
               end
               // divider keeps its low bits; prescale count is left alone
               mtmr_pkg::REG_DIVIDER:
                  sh_divider = w.write_data[mtmr_pkg::DIVIDER_BITS-1:0];
               mtmr_pkg::REG_TIME_LO: sh_time_count[31:0] = w.write_data;
               mtmr_pkg::REG_TIME_HI: sh_time_count[63:32] = w.write_data;
               mtmr_pkg::REG_CMP_LO:  sh_compare[31:0] = w.write_data;
               mtmr_pkg::REG_CMP_HI:  sh_compare[63:32] = w.write_data;
               default: ;
            endcase
         end
         default: ;
      endcase
      timer_rsp_q.push_back('{read_data: rd, irq: (sh_time_count >= sh_compare)});
   endtask

   task automatic add_word(input logic [1:0] kind, input logic ext,
                           input logic [2:0] idx, input logic [31:0] data);
      pending_words_q.push_back('{kind: kind, ext_pulse: ext, reg_index: idx,
                                  write_data: data});
   endtask

   // ------------------------------------------------------------------
   // Request driver: one word per handshake, random gaps between words.
   // Gaps come in stretches: burst mode sends back to back.
   // ------------------------------------------------------------------
   mtmr_pkg::item_type next_word;
   int                 send_gap = 0;
   bit                 send_burst = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            step_timer_shadow({req_type, req_ext_pulse, req_reg_index, req_write_data});
            words_accepted++;
         end
         // hold the word while it waits for ready
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_words_q.size() != 0) begin
               next_word = pending_words_q.pop_front();
               req_type       <= next_word.kind;
               req_ext_pulse  <= next_word.ext_pulse;
               req_reg_index  <= next_word.reg_index;
               req_write_data <= next_word.write_data;
               req_valid      <= 1'b1;
               if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
               send_gap = send_burst ? 0 :
                          ($urandom_range(0, 1) ? $urandom_range(0, 17) : 0);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor: random stalls on rsp_ready, compare against the
   // oldest owed response.
   // ------------------------------------------------------------------
   timer_rsp_type owed;
   int            recv_stall = 0;
   bit            recv_burst = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (timer_rsp_q.size() == 0) begin
               $display("%0t: unexpected rsp word, read_data %h irq %b",
                        $time, rsp_read_data, rsp_timer_irq);
               mismatch_count++;
            end else begin
               owed = timer_rsp_q.pop_front();
               if (rsp_read_data !== owed.read_data) begin
                  $display("%0t: read_data mismatch, expected %h actual %h",
                           $time, owed.read_data, rsp_read_data);
                  mismatch_count++;
               end
               if (rsp_timer_irq !== owed.irq) begin
                  $display("%0t: timer_irq mismatch, expected %b actual %b",
                           $time, owed.irq, rsp_timer_irq);
                  mismatch_count++;
               end
            end
            if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
            recv_stall = recv_burst ? 0 :
                         ($urandom_range(0, 1) ? $urandom_range(0, 17) : 0);
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: trips when nothing moves on either channel for too long.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run.
   // ------------------------------------------------------------------
   initial begin : stimulus
      int          pick;
      logic [2:0]  idx;
      logic [31:0] data;

      // reset values: control, compare halves, an unused index
      add_word(mtmr_pkg::REQ_READ, 1'b0, mtmr_pkg::REG_CONTROL, '0);
      add_word(mtmr_pkg::REQ_READ, 1'b0, mtmr_pkg::REG_CMP_LO, '0);
      add_word(mtmr_pkg::REQ_READ, 1'b0, mtmr_pkg::REG_CMP_HI, '0);
      add_word(mtmr_pkg::REQ_READ, 1'b1, REG_SPARE, 32'hFFFF_FFFF);
      // tick while disabled must not count
      add_word(mtmr_pkg::REQ_TICK, 1'b1, mtmr_pkg::REG_CONTROL, '0);
      // divider write truncates to the low bits
      add_word(mtmr_pkg::REQ_WRITE, 1'b0, mtmr_pkg::REG_DIVIDER, 32'hFFFF_FFFF);
      add_word(mtmr_pkg::REQ_READ, 1'b0, mtmr_pkg::REG_DIVIDER, '0);
      add_word(mtmr_pkg::REQ_WRITE, 1'b0, mtmr_pkg::REG_DIVIDER, '0);
      // enable on core clock, junk in the upper control bits
      add_word(mtmr_pkg::REQ_WRITE, 1'b0, mtmr_pkg::REG_CONTROL, 32'hFFFF_FFFD);
      add_word(mtmr_pkg::REQ_READ, 1'b0, mtmr_pkg::REG_CONTROL, '0);
      // time two below wrap, compare at max: irq rises, then time wraps
      add_word(mtmr_pkg::REQ_WRITE, 1'b0, mtmr_pkg::REG_TIME_LO, 32'hFFFF_FFFE);
      add_word(mtmr_pkg::REQ_WRITE, 1'b0, mtmr_pkg::REG_TIME_HI, 32'hFFFF_FFFF);
      add_word(mtmr_pkg::REQ_WRITE, 1'b0, mtmr_pkg::REG_CMP_LO, 32'hFFFF_FFFF);
      add_word(mtmr_pkg::REQ_TICK, 1'b0, mtmr_pkg::REG_CONTROL, '0);
      add_word(mtmr_pkg::REQ_TICK, 1'b0, mtmr_pkg::REG_CONTROL, '0);
      add_word(mtmr_pkg::REQ_WRITE, 1'b0, mtmr_pkg::REG_CMP_HI, '0);
      add_word(mtmr_pkg::REQ_WRITE, 1'b0, mtmr_pkg::REG_CMP_LO, 32'd2);
      // raise the divider, then shrink it below the running prescale count
      add_word(mtmr_pkg::REQ_WRITE, 1'b0, mtmr_pkg::REG_DIVIDER, 32'd3);
      add_word(mtmr_pkg::REQ_TICK, 1'b0, mtmr_pkg::REG_CONTROL, '0);
      add_word(mtmr_pkg::REQ_TICK, 1'b0, mtmr_pkg::REG_CONTROL, '0);
      add_word(mtmr_pkg::REQ_WRITE, 1'b0, mtmr_pkg::REG_DIVIDER, 32'd1);
      add_word(mtmr_pkg::REQ_TICK, 1'b0, mtmr_pkg::REG_CONTROL, '0);
      // external source: only flagged ticks count
      add_word(mtmr_pkg::REQ_WRITE, 1'b0, mtmr_pkg::REG_CONTROL, 32'd3);
      add_word(mtmr_pkg::REQ_TICK, 1'b0, mtmr_pkg::REG_CONTROL, '0);
      add_word(mtmr_pkg::REQ_TICK, 1'b1, mtmr_pkg::REG_CONTROL, '0);
      // ignored write, unused request kind, then read back time
      add_word(mtmr_pkg::REQ_WRITE, 1'b1, REG_UNUSED, 32'hFFFF_FFFF);
      add_word(REQ_UNUSED, 1'b1, REG_SPARE, 32'hFFFF_FFFF);
      add_word(mtmr_pkg::REQ_READ, 1'b0, mtmr_pkg::REG_TIME_LO, '0);
      add_word(mtmr_pkg::REQ_READ, 1'b0, mtmr_pkg::REG_TIME_HI, '0);

      // Random part. Time and compare mostly stay small so the compare
      // crosses time often; full-width and near-carry values mixed in.
      repeat (RANDOM_WORDS) begin
         pick = $urandom_range(0, 99);
         idx  = 3'($urandom_range(0, 7));
         data = $urandom();
         if (pick < 55) begin
            add_word(mtmr_pkg::REQ_TICK, 1'($urandom_range(0, 1)), idx, data);
         end else if (pick < 70) begin
            add_word(mtmr_pkg::REQ_READ, 1'($urandom_range(0, 1)), idx, data);
         end else if (pick < 96) begin
            case (idx)
               mtmr_pkg::REG_CONTROL: begin
                  if ($urandom_range(0, 4) != 0) data[mtmr_pkg::CTRL_ENABLE_BIT] = 1'b1;
               end
               mtmr_pkg::REG_DIVIDER: begin
                  if ($urandom_range(0, 6) != 0) data = $urandom_range(0, 3);
               end
               mtmr_pkg::REG_TIME_LO, mtmr_pkg::REG_CMP_LO: begin
                  pick = $urandom_range(0, 9);
                  if (pick < 7) data = $urandom_range(0, 1500);
                  else if (pick == 7) data = 32'hFFFF_FFF0 | $urandom_range(0, 15);
               end
               mtmr_pkg::REG_TIME_HI, mtmr_pkg::REG_CMP_HI: begin
                  pick = $urandom_range(0, 9);
                  if (pick < 8) data = '0;
                  else if (pick == 8) data = 32'hFFFF_FFFF;
               end
               default: ;
            endcase
            add_word(mtmr_pkg::REQ_WRITE, 1'($urandom_range(0, 1)), idx, data);
         end else begin
            add_word(REQ_UNUSED, 1'($urandom_range(0, 1)), idx, data);
         end
      end
      words_total = pending_words_q.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (words_accepted != words_total) @(posedge clock);
      while (timer_rsp_q.size() != 0) @(posedge clock);
      // wait on to catch any stray response
      repeat (8) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### sim.f
rtl/mtmr_pkg.sv
rtl/mtmr_prescale.sv
rtl/mtmr_regs.sv
rtl/machine_timer_with_prescaler.sv
tb/sv/tb_machine_timer_with_prescaler.sv
